// File: hw/rtl/zid_pkg.sv
// ----------------------------------------------------------------------------
// zid_pkg: shared constants for the zone intrusion window detector
// Register map indexes, counter widths and fixed limits.
// ----------------------------------------------------------------------------
package zid_pkg;

    // register indexes on the configuration port (byte address = 4 * index)
    localparam logic [2:0] REG_CUT_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_CUT_WINDOW        = 3'd1;
    localparam logic [2:0] REG_CUT_COUNT_LIMIT   = 3'd2;
    localparam logic [2:0] REG_CLIMB_THRESHOLD   = 3'd3;
    localparam logic [2:0] REG_CLIMB_WINDOW      = 3'd4;
    localparam logic [2:0] REG_CLIMB_COUNT_LIMIT = 3'd5;
    localparam logic [2:0] REG_CABLE_BREAK_LEVEL = 3'd6;
    localparam logic [2:0] REG_CABLE_BREAK_TICKS = 3'd7;

    localparam int ADDR_BITS  = 5;
    localparam int LIMIT_BITS = 16;
    localparam int CABLE_BITS = 14;
    localparam int PHASE_BITS = 22;

    localparam logic [PHASE_BITS-1:0] PHASE_WRAP  = 22'd3600000;
    localparam logic [CABLE_BITS-1:0] CABLE_MAX   = 14'd16383;
    localparam logic [CABLE_BITS-1:0] CABLE_TICKS_RESET = 14'd12000;

    // result word bit positions
    localparam int OUT_EVENT = 0;
    localparam int OUT_ALARM = 1;
    localparam int OUT_ERROR = 2;
    localparam int OUT_ARMED = 3;
    localparam int OUT_BITS  = 8;

endpackage

// File: hw/rtl/zone_intrusion_window_detector_top.sv
// ----------------------------------------------------------------------------
// zone_intrusion_window_detector_top: one-zone cut/climb intrusion detector
// Per-tick cable check, cut detector and decimated climb detector.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on s_* is one sample tick of the zone. Each accepted word
//   produces exactly one result word on m_*, holding the event bit and the
//   alarm, error and armed status after that tick.
//   Latency: the result is valid the cycle after the input word is accepted.
//   Throughput: one word per cycle; all tick logic (phase and cable counters,
//   both window detectors) sits between the input port and the result
//   register, with the climb detector chained behind the cut detector.
//   Stall: the result register holds while m_tready is low; s_tready stays
//   high as long as the result register is empty or being drained, so a new
//   word is taken in the same cycle the previous result leaves.
//   Reset: rst_n clears all counters and detectors, sets the zone armed and
//   loads the register defaults (cable level all ones, break ticks 12000). The user
//   must write configuration over the APB port while no word is in flight (unchecked).
// ----------------------------------------------------------------------------
module zone_intrusion_window_detector_top
    import zid_pkg::*;
#(
    parameter int SAMPLE_BITS  = 12,
    parameter int WINDOW_BITS  = 20,
    parameter int CLIMB_DIVIDE = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, low bit up: sensor_sample, cable_sample, zone_enable, rearm, zero fill
    input  logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, low bit up: alarm_event, alarm_flag, error_flag, armed, zero fill
    output logic [OUT_BITS-1:0]  m_tdata,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int DIV_BITS = (CLIMB_DIVIDE > 1) ? $clog2(CLIMB_DIVIDE) : 1;
    localparam logic [DIV_BITS-1:0] DIV_LAST = DIV_BITS'(CLIMB_DIVIDE - 1);
    localparam logic [SAMPLE_BITS-1:0] LEVEL_RESET = SAMPLE_BITS'(4095);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] cut_threshold_reg;
    logic [WINDOW_BITS-1:0] cut_window_reg;
    logic [LIMIT_BITS-1:0]  cut_count_limit_reg;
    logic [SAMPLE_BITS-1:0] climb_threshold_reg;
    logic [WINDOW_BITS-1:0] climb_window_reg;
    logic [LIMIT_BITS-1:0]  climb_count_limit_reg;
    logic [SAMPLE_BITS-1:0] cable_break_level_reg;
    logic [CABLE_BITS-1:0]  cable_break_ticks_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_threshold_reg     <= '0;
            cut_window_reg        <= '0;
            cut_count_limit_reg   <= '0;
            climb_threshold_reg   <= '0;
            climb_window_reg      <= '0;
            climb_count_limit_reg <= '0;
            cable_break_level_reg <= LEVEL_RESET;
            cable_break_ticks_reg <= CABLE_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CUT_THRESHOLD:     cut_threshold_reg     <= pwdata[SAMPLE_BITS-1:0];
                REG_CUT_WINDOW:        cut_window_reg        <= pwdata[WINDOW_BITS-1:0];
                REG_CUT_COUNT_LIMIT:   cut_count_limit_reg   <= pwdata[LIMIT_BITS-1:0];
                REG_CLIMB_THRESHOLD:   climb_threshold_reg   <= pwdata[SAMPLE_BITS-1:0];
                REG_CLIMB_WINDOW:      climb_window_reg      <= pwdata[WINDOW_BITS-1:0];
                REG_CLIMB_COUNT_LIMIT: climb_count_limit_reg <= pwdata[LIMIT_BITS-1:0];
                REG_CABLE_BREAK_LEVEL: cable_break_level_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_CABLE_BREAK_TICKS: cable_break_ticks_reg <= pwdata[CABLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_index)
            REG_CUT_THRESHOLD:     prdata = 32'(cut_threshold_reg);
            REG_CUT_WINDOW:        prdata = 32'(cut_window_reg);
            REG_CUT_COUNT_LIMIT:   prdata = 32'(cut_count_limit_reg);
            REG_CLIMB_THRESHOLD:   prdata = 32'(climb_threshold_reg);
            REG_CLIMB_WINDOW:      prdata = 32'(climb_window_reg);
            REG_CLIMB_COUNT_LIMIT: prdata = 32'(climb_count_limit_reg);
            REG_CABLE_BREAK_LEVEL: prdata = 32'(cable_break_level_reg);
            REG_CABLE_BREAK_TICKS: prdata = 32'(cable_break_ticks_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input word unpack and handshake
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] sensor_sample;
    logic [SAMPLE_BITS-1:0] cable_sample;
    logic                   zone_enable;
    logic                   rearm;
    logic                   in_accept;

    assign sensor_sample = s_tdata[SAMPLE_BITS-1:0];
    assign cable_sample  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign zone_enable   = s_tdata[2*SAMPLE_BITS];
    assign rearm         = s_tdata[2*SAMPLE_BITS+1];

    assign s_tready  = !m_tvalid || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // zone state
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [DIV_BITS-1:0]   div_reg, div_next;
    logic [CABLE_BITS-1:0] cable_count_reg, cable_count_next;
    logic                  cable_broken_reg, cable_broken_next;
    logic                  alarm_reg, alarm_next;
    logic                  error_reg, error_next;
    logic                  armed_reg, armed_next;

    logic armed_now;
    logic zone_run;
    logic cut_step, climb_step;
    logic cut_fire, climb_fire;
    logic event_now;

    // phase counter and its residue modulo the climb divider
    always_comb
    begin
        if (phase_reg >= PHASE_WRAP)
        begin
            phase_next = '0;
            div_next   = '0;
        end
        else
        begin
            phase_next = phase_reg + 1'b1;
            div_next   = (div_reg == DIV_LAST) ? '0 : div_reg + 1'b1;
        end
    end

    // cable check
    always_comb
    begin
        armed_now = armed_reg || rearm;
        zone_run  = zone_enable && armed_now;

        cable_count_next  = cable_count_reg;
        cable_broken_next = 1'b0;
        if (zone_run)
        begin
            if (cable_sample > cable_break_level_reg && !cable_broken_reg)
            begin
                cable_count_next  = (cable_count_reg < CABLE_MAX) ?
                                    cable_count_reg + 1'b1 : cable_count_reg;
                cable_broken_next = cable_count_next > cable_break_ticks_reg;
            end
            else
            begin
                cable_count_next = '0;
            end
        end
    end

    // detector gating
    assign cut_step   = in_accept && zone_run && !cable_broken_next;
    assign climb_step = cut_step && !cut_fire && (div_next == '0);
    assign event_now  = cut_fire || climb_fire;

    // zone status after this tick
    always_comb
    begin
        if (zone_run)
        begin
            alarm_next = alarm_reg || event_now;
            armed_next = armed_now && !event_now;
            error_next = error_reg || cable_broken_next;
        end
        else
        begin
            alarm_next = 1'b0;
            armed_next = armed_now;
            error_next = 1'b0;
        end
    end

    // the climb detector only steps when the cut detector stayed quiet
    zid_window_det #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_cut_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (cut_step),
        .sample    (sensor_sample),
        .threshold (cut_threshold_reg),
        .window    (cut_window_reg),
        .limit     (cut_count_limit_reg),
        .fire      (cut_fire)
    );

    zid_window_det #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WINDOW_BITS (WINDOW_BITS)
    ) u_climb_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (climb_step),
        .sample    (sensor_sample),
        .threshold (climb_threshold_reg),
        .window    (climb_window_reg),
        .limit     (climb_count_limit_reg),
        .fire      (climb_fire)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            div_reg          <= '0;
            cable_count_reg  <= '0;
            cable_broken_reg <= 1'b0;
            alarm_reg        <= 1'b0;
            error_reg        <= 1'b0;
            armed_reg        <= 1'b1;
        end
        else if (in_accept)
        begin
            phase_reg        <= phase_next;
            div_reg          <= div_next;
            cable_count_reg  <= cable_count_next;
            cable_broken_reg <= cable_broken_next;
            alarm_reg        <= alarm_next;
            error_reg        <= error_next;
            armed_reg        <= armed_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic                m_valid_reg;
    logic [OUT_BITS-1:0] m_data_reg;
    logic [OUT_BITS-1:0] m_data_next;

    always_comb
    begin
        m_data_next            = '0;
        m_data_next[OUT_EVENT] = event_now;
        m_data_next[OUT_ALARM] = alarm_next;
        m_data_next[OUT_ERROR] = error_next;
        m_data_next[OUT_ARMED] = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hw/rtl/zid_window_det.sv
// ----------------------------------------------------------------------------
// zid_window_det: windowed hit-count detector
// Opens a window on the first sample above threshold, counts hits and fires
// when the count reaches the limit while window ticks remain.
// ----------------------------------------------------------------------------
module zid_window_det
    import zid_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int WINDOW_BITS = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] threshold,
    input  logic [WINDOW_BITS-1:0] window,
    input  logic [LIMIT_BITS-1:0]  limit,
    output logic                   fire
);

    localparam int CMP_BITS = (WINDOW_BITS > LIMIT_BITS) ? WINDOW_BITS : LIMIT_BITS;
    localparam logic [WINDOW_BITS-1:0] HITS_MAX = {WINDOW_BITS{1'b1}};

    logic                   active_reg, active_next;
    logic [WINDOW_BITS-1:0] hits_reg, hits_next;
    logic [WINDOW_BITS-1:0] remaining_reg, remaining_next;

    logic                   above;
    logic                   open_now;
    logic [WINDOW_BITS-1:0] rem_start;
    logic [WINDOW_BITS-1:0] rem_dec;
    logic [WINDOW_BITS-1:0] hits_kept;
    logic [WINDOW_BITS-1:0] hits_inc;
    logic                   rem_left;

    // one detector step; fire only rises on a step
    always_comb
    begin
        above     = sample > threshold;
        open_now  = !active_reg && above;
        rem_start = open_now ? window : remaining_reg;
        rem_left  = rem_start != '0;
        rem_dec   = rem_left ? rem_start - 1'b1 : rem_start;
        hits_kept = rem_left ? hits_reg : '0;
        hits_inc  = (above && hits_kept != HITS_MAX) ? hits_kept + 1'b1 : hits_kept;

        active_next    = active_reg;
        hits_next      = hits_reg;
        remaining_next = remaining_reg;
        fire           = 1'b0;

        if (step && (active_reg || above))
        begin
            active_next    = rem_left;
            hits_next      = hits_inc;
            remaining_next = rem_dec;
            // a fire needs ticks left after this one's decrement
            if (CMP_BITS'(hits_inc) >= CMP_BITS'(limit) && rem_dec != '0)
            begin
                fire           = 1'b1;
                active_next    = 1'b0;
                remaining_next = '0;
                hits_next      = '0;
            end
        end
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            hits_reg      <= '0;
            remaining_reg <= '0;
        end
        else if (step)
        begin
            active_reg    <= active_next;
            hits_reg      <= hits_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// File: hw/rtl/zid_checker.sv
// ----------------------------------------------------------------------------
// zid_checker: port-level checks for the zone intrusion window detector
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module zid_checker
    import zid_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an empty result register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result register");

    // a drained result with no new word leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result word repeated");

    // a fired detector raises the alarm and disarms the zone
    a_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_EVENT] |-> m_tdata[OUT_ALARM] && !m_tdata[OUT_ARMED])
        else $error("event without alarm or with zone still armed");

endmodule

bind zone_intrusion_window_detector_top zid_checker u_zid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb_zone_intrusion_window_detector_top.sv
// ----------------------------------------------------------------------------
// tb_zone_intrusion_window_detector_top: self-checking bench for one zone
// Drives sample-tick words into the stream input, predicts the event, alarm,
// error and armed bits of each tick in a cycle-free model, and compares every
// result word with the oldest prediction. Registers are written and read back
// over APB between phases: directed ticks first, then randomized phases.
// ----------------------------------------------------------------------------
module tb_zone_intrusion_window_detector_top;
    import zid_pkg::*;

    localparam int CLIMB_EVERY   = 4;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASE_TICKS   = 50;
    localparam int RANDOM_PHASES = 10;

    // one sample tick as it sits in s_tdata, sensor in the low bits
    typedef struct packed {
        logic        rearm;
        logic        zone_enable;
        logic [11:0] cable_sample;
        logic [11:0] sensor_sample;
    } tick_t;

    // one result word, alarm_event in bit 0
    typedef struct packed {
        logic armed;
        logic error_flag;
        logic alarm_flag;
        logic alarm_event;
    } status_t;

    // window detector state plus the fire strobe of the last step
    typedef struct packed {
        logic        fired;
        logic        active;
        logic [19:0] hits;
        logic [19:0] remaining;
    } window_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_BITS-1:0] paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    zone_intrusion_window_detector_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // stimulus and expectations
    tick_t   tick_queue[$];
    status_t status_expect_q[$];
    int      mismatches = 0;
    bit      idle_on    = 1'b0;
    int      send_gap;
    int      sink_gap;
    tick_t   sent_tick;
    int      quiet_cycles = 0;
    string   field_name[4] = '{"alarm_event", "alarm_flag", "error_flag", "armed"};

    // model copy of the registers and the zone state
    logic [31:0] reg_shadow[8];
    logic [21:0] phase_ctr;
    logic [13:0] cable_run;
    logic        cable_fault;
    logic        zone_alarm;
    logic        zone_error;
    logic        zone_armed;
    window_t     cut_state;
    window_t     climb_state;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // one step of a window detector
    function automatic window_t advance_window(window_t w, logic [11:0] sample,
                                               logic [11:0] thr, logic [19:0] len,
                                               logic [15:0] lim);
        logic above;
        above   = sample > thr;
        w.fired = 1'b0;
        if (!w.active && above)
        begin
            w.active    = 1'b1;
            w.remaining = len;
        end
        if (w.active)
        begin
            if (w.remaining != '0)
                w.remaining = w.remaining - 1'b1;
            else
            begin
                // window ran out; a hit on this tick still counts
                w.active = 1'b0;
                w.hits   = '0;
            end
            if (above && w.hits != '1)
                w.hits = w.hits + 1'b1;
            if (w.hits >= lim && w.remaining != '0)
            begin
                w.active    = 1'b0;
                w.remaining = '0;
                w.hits      = '0;
                w.fired     = 1'b1;
            end
        end
        return w;
    endfunction

    // predict the result word of one accepted tick
    task automatic zone_tick_model(input tick_t t);
        status_t r;
        logic    fire;
        fire = 1'b0;
        if (phase_ctr >= PHASE_WRAP)
            phase_ctr = '0;
        else
            phase_ctr = phase_ctr + 1'b1;
        if (t.rearm)
            zone_armed = 1'b1;
        if (t.zone_enable && zone_armed)
        begin
            if (t.cable_sample > reg_shadow[REG_CABLE_BREAK_LEVEL][11:0] && !cable_fault)
            begin
                if (cable_run < CABLE_MAX)
                    cable_run = cable_run + 1'b1;
                if (cable_run > reg_shadow[REG_CABLE_BREAK_TICKS][13:0])
                    cable_fault = 1'b1;
            end
            else
            begin
                cable_fault = 1'b0;
                cable_run   = '0;
            end
            if (!cable_fault)
            begin
                cut_state = advance_window(cut_state, t.sensor_sample,
                                           reg_shadow[REG_CUT_THRESHOLD][11:0],
                                           reg_shadow[REG_CUT_WINDOW][19:0],
                                           reg_shadow[REG_CUT_COUNT_LIMIT][15:0]);
                fire = cut_state.fired;
                if (!fire && (phase_ctr % CLIMB_EVERY) == 0)
                begin
                    climb_state = advance_window(climb_state, t.sensor_sample,
                                                 reg_shadow[REG_CLIMB_THRESHOLD][11:0],
                                                 reg_shadow[REG_CLIMB_WINDOW][19:0],
                                                 reg_shadow[REG_CLIMB_COUNT_LIMIT][15:0]);
                    fire = climb_state.fired;
                end
                if (fire)
                begin
                    zone_alarm = 1'b1;
                    zone_armed = 1'b0;
                end
            end
        end
        else
        begin
            cable_fault = 1'b0;
            zone_alarm  = 1'b0;
            zone_error  = 1'b0;
        end
        if (cable_fault)
            zone_error = 1'b1;
        r.alarm_event = fire;
        r.alarm_flag  = zone_alarm;
        r.error_flag  = zone_error;
        r.armed       = zone_armed;
        status_expect_q.push_back(r);
    endtask

    // input driver: one tick word at a time, a random gap after each word while idle_on is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                zone_tick_model(sent_tick);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0 || tick_queue.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap = send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    sent_tick = tick_queue.pop_front();
                    s_tdata  <= {6'b0, sent_tick};
                    s_tvalid <= 1'b1;
                    send_gap = idle_on ? $urandom_range(0, 3) : 0;
                end
            end
        end
    end

    // result monitor: compare each word with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        status_t exp;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (status_expect_q.size() == 0)
                begin
                    $error("unexpected result word %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    exp = status_expect_q.pop_front();
                    for (int b = 0; b < 4; b++)
                    begin
                        if (m_tdata[b] !== exp[b])
                        begin
                            $error("%s expected %0d got %0d", field_name[b], exp[b],
                                   m_tdata[b]);
                            mismatches++;
                        end
                    end
                    if (m_tdata[OUT_BITS-1:4] !== '0)
                    begin
                        $error("zero fill expected 0 got %h", m_tdata[OUT_BITS-1:4]);
                        mismatches++;
                    end
                end
                sink_gap = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (sink_gap > 0)
            begin
                m_tready <= 1'b0;
                sink_gap = sink_gap - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // APB write followed by a read-back of the same register
    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        reg_shadow[idx] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
        begin
            $error("register %0d expected %h got %h", idx, value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_tick(input int sensor, input int cable, input bit en, input bit rearm);
        tick_t t;
        t.sensor_sample = 12'(sensor);
        t.cable_sample  = 12'(cable);
        t.zone_enable   = en;
        t.rearm         = rearm;
        tick_queue.push_back(t);
    endtask

    // wait until every tick is sent and every result checked; sampled on the
    // falling edge so the driver's updates of this cycle have settled
    task automatic drain();
        while (tick_queue.size() != 0 || s_tvalid || status_expect_q.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic logic [31:0] rand_window();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1048575;
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd65535;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic int near_level(int thr);
        int v;
        v = thr + $urandom_range(0, 6) - 3;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // main sequence
    initial
    begin
        int  sensor;
        int  cable;
        int  lvl;
        bit  burst;
        reg_shadow[REG_CUT_THRESHOLD]     = '0;
        reg_shadow[REG_CUT_WINDOW]        = '0;
        reg_shadow[REG_CUT_COUNT_LIMIT]   = '0;
        reg_shadow[REG_CLIMB_THRESHOLD]   = '0;
        reg_shadow[REG_CLIMB_WINDOW]      = '0;
        reg_shadow[REG_CLIMB_COUNT_LIMIT] = '0;
        reg_shadow[REG_CABLE_BREAK_LEVEL] = 32'd4095;
        reg_shadow[REG_CABLE_BREAK_TICKS] = 32'(CABLE_TICKS_RESET);
        phase_ctr   = '0;
        cable_run   = '0;
        cable_fault = 1'b0;
        zone_alarm  = 1'b0;
        zone_error  = 1'b0;
        zone_armed  = 1'b1;
        cut_state   = '0;
        climb_state = '0;
        burst       = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cut firing, disarm and rearm, cable break, window expiry
        set_reg(REG_CUT_THRESHOLD, 32'd100);
        set_reg(REG_CUT_WINDOW, 32'd5);
        set_reg(REG_CUT_COUNT_LIMIT, 32'd3);
        set_reg(REG_CLIMB_THRESHOLD, 32'd4095);
        set_reg(REG_CLIMB_WINDOW, 32'd0);
        set_reg(REG_CLIMB_COUNT_LIMIT, 32'd0);
        set_reg(REG_CABLE_BREAK_LEVEL, 32'd2000);
        set_reg(REG_CABLE_BREAK_TICKS, 32'd2);
        push_tick(0, 0, 1'b0, 1'b0);
        push_tick(4095, 4095, 1'b0, 1'b1);
        push_tick(4095, 0, 1'b1, 1'b0);
        push_tick(200, 0, 1'b1, 1'b0);
        push_tick(50, 0, 1'b1, 1'b0);
        push_tick(300, 0, 1'b1, 1'b0);
        push_tick(4095, 0, 1'b1, 1'b0);
        push_tick(0, 0, 1'b1, 1'b1);
        repeat (5) push_tick(0, 4095, 1'b1, 1'b0);
        push_tick(0, 0, 1'b0, 1'b0);
        push_tick(200, 0, 1'b1, 1'b0);
        repeat (4) push_tick(0, 0, 1'b1, 1'b0);
        push_tick(200, 0, 1'b1, 1'b0);
        push_tick(200, 0, 1'b1, 1'b0);
        drain();

        // directed: zero limit on a huge climb window, zero cut window
        set_reg(REG_CUT_THRESHOLD, 32'd0);
        set_reg(REG_CUT_WINDOW, 32'd0);
        set_reg(REG_CUT_COUNT_LIMIT, 32'd65535);
        set_reg(REG_CLIMB_THRESHOLD, 32'd0);
        set_reg(REG_CLIMB_WINDOW, 32'd1048575);
        set_reg(REG_CABLE_BREAK_LEVEL, 32'd0);
        set_reg(REG_CABLE_BREAK_TICKS, 32'd16383);
        for (int i = 0; i < 6; i++)
            push_tick(1, 0, 1'b1, i[0]);
        drain();

        // random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_reg(REG_CUT_THRESHOLD, rand_level());
            set_reg(REG_CUT_WINDOW, rand_window());
            set_reg(REG_CUT_COUNT_LIMIT, rand_limit());
            set_reg(REG_CLIMB_THRESHOLD, rand_level());
            set_reg(REG_CLIMB_WINDOW, rand_window());
            set_reg(REG_CLIMB_COUNT_LIMIT, rand_limit());
            set_reg(REG_CABLE_BREAK_LEVEL, rand_level());
            case ($urandom_range(0, 5))
                0:       set_reg(REG_CABLE_BREAK_TICKS, 32'd0);
                1:       set_reg(REG_CABLE_BREAK_TICKS, 32'd16383);
                default: set_reg(REG_CABLE_BREAK_TICKS, $urandom_range(1, 30));
            endcase
            idle_on = (p == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            lvl = reg_shadow[REG_CABLE_BREAK_LEVEL];
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    burst = !burst;
                case ($urandom_range(0, 3))
                    0:       sensor = $urandom_range(0, 4095);
                    1:       sensor = near_level(reg_shadow[REG_CUT_THRESHOLD]);
                    2:       sensor = near_level(reg_shadow[REG_CLIMB_THRESHOLD]);
                    default: sensor = $urandom_range(2048, 4095);
                endcase
                // cable above the level in bursts, mostly below otherwise
                if (burst)
                    cable = (lvl < 4095) ? $urandom_range(lvl + 1, 4095) : 4095;
                else if ($urandom_range(0, 7) == 0 || lvl == 0)
                    cable = $urandom_range(0, 4095);
                else
                    cable = $urandom_range(0, lvl);
                push_tick(sensor, cable, $urandom_range(0, 15) != 0,
                          $urandom_range(0, 4) == 0);
            end
            drain();
        end

        if (mismatches == 0 && status_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
